// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assertion macros used by the checker file
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_HOLDS(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen outside reset
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ===== rtl/ipe_pkg.sv =====
// ---------------------------------------------------------------------------
// ipe_pkg
// Types, widths and color helpers of the indexed palette engine.
// ---------------------------------------------------------------------------
package ipe_pkg;

  localparam int REQ_W   = 2;
  localparam int IDX_W   = 8;
  localparam int COMP_W  = 8;
  localparam int COLOR_W = 16;
  localparam int DIST_W  = 18;

  // largest squared distance over three 8-bit components
  localparam logic [DIST_W-1:0] MAX_DIST = 18'd195075;

  typedef enum logic [REQ_W-1:0] {
    REQ_WRITE  = 2'd0,
    REQ_LOOKUP = 2'd1,
    REQ_SEARCH = 2'd2
  } req_t;

  // truncate 8-bit components to 5/6/5 and pack
  function automatic logic [COLOR_W-1:0] pack565(
    input logic [COMP_W-1:0] r,
    input logic [COMP_W-1:0] g,
    input logic [COMP_W-1:0] b
  );
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

  // squared distance between a widened palette color and an rgb triple
  function automatic logic [DIST_W-1:0] color_dist(
    input logic [COLOR_W-1:0] c,
    input logic [COMP_W-1:0]  r,
    input logic [COMP_W-1:0]  g,
    input logic [COMP_W-1:0]  b
  );
    logic [COMP_W-1:0]   cr, cg, cb;
    logic [COMP_W-1:0]   dr, dg, db;
    logic [2*COMP_W-1:0] sr, sg, sb;
    cr = {c[15:11], 3'b000};
    cg = {c[10:5], 2'b00};
    cb = {c[4:0], 3'b000};
    dr = (r >= cr) ? (r - cr) : (cr - r);
    dg = (g >= cg) ? (g - cg) : (cg - g);
    db = (b >= cb) ? (b - cb) : (cb - b);
    sr = dr * dr;
    sg = dg * dg;
    sb = db * db;
    return DIST_W'(sr) + DIST_W'(sg) + DIST_W'(sb);
  endfunction

endpackage

// ===== rtl/ipe_if.sv =====
// ---------------------------------------------------------------------------
// ipe_if
// Request and response channels of the indexed palette engine.
// ---------------------------------------------------------------------------
interface ipe_req_if import ipe_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [REQ_W-1:0]   req_type;
  logic [IDX_W-1:0]   entry_index;
  logic [COMP_W-1:0]  red;
  logic [COMP_W-1:0]  green;
  logic [COMP_W-1:0]  blue;

  modport source (output valid, req_type, entry_index, red, green, blue, input ready);
  modport sink   (input valid, req_type, entry_index, red, green, blue, output ready);
endinterface

interface ipe_rsp_if import ipe_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] color_565;
  logic [IDX_W-1:0]   best_index;
  logic [DIST_W-1:0]  best_distance;

  modport source (output valid, color_565, best_index, best_distance, input ready);
  modport sink   (input valid, color_565, best_index, best_distance, output ready);
endinterface

// ===== rtl/indexed_palette_engine_unit.sv =====
// Flow: a write or unused code loads the pending result on accept, a lookup reads
// its entry in S_LOOK before the next accept, a search walks S_SCAN until the
// first exact match or last entry. One write per cycle unless the output stalls;
// a search holds the engine, reading one entry per cycle on the single read port.
// Reset (synchronous, rst_n low) clears the per-entry valid bits, so every entry
// reads as zero at once; no clearing sweep is needed.
// ---------------------------------------------------------------------------
// indexed_palette_engine_unit
// RGB565 palette with writes, pixel lookups and a nearest-color search.
// ---------------------------------------------------------------------------
module indexed_palette_engine_unit import ipe_pkg::*; #(
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  ipe_req_if.sink    in_req,
  ipe_rsp_if.source  out_rsp
);

  localparam int AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam int CW = $clog2(PALETTE_ENTRIES + 1);
  localparam logic [AW-1:0]  LAST_IDX   = AW'(PALETTE_ENTRIES - 1);
  localparam logic [CW-1:0]  SCAN_END   = CW'(PALETTE_ENTRIES);
  localparam logic [IDX_W:0] ENTRY_LIM  = (IDX_W + 1)'(PALETTE_ENTRIES);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOOK = 4'b0010,
    S_SCAN = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state_r, state_nxt, acc_state;

  // palette memory and per-entry valid bits
  logic [COLOR_W-1:0]         mem [PALETTE_ENTRIES];
  logic [PALETTE_ENTRIES-1:0] vld_r;
  logic [COLOR_W-1:0]         rd_data_r;
  logic                       rd_vld_r;
  logic                       mem_we, mem_re;
  logic [AW-1:0]              rd_addr, wr_addr;
  logic [COLOR_W-1:0]         wr_color;

  // handshake
  logic in_ready, in_acc, out_free;
  req_t req_sel;
  logic in_range;

  // lookup
  logic look_ok_r;

  // search walk
  logic [CW-1:0]      scan_addr_r;
  logic               issue;
  logic               rd_live_r;
  logic [AW-1:0]      rd_idx_r;
  logic [COLOR_W-1:0] ent_color;
  logic               dist_live_r;
  logic [DIST_W-1:0]  dist_r;
  logic [AW-1:0]      dist_idx_r;
  logic [COLOR_W-1:0] dist_color_r;
  logic               have_best_r;
  logic               last_seen_r;
  logic [DIST_W-1:0]  best_d_r;
  logic [AW-1:0]      best_idx_r;
  logic [COLOR_W-1:0] best_color_r;
  logic               take;
  logic               done_scan;
  logic [COMP_W-1:0]  srch_red_r, srch_green_r, srch_blue_r;

  // pending result and output register
  logic               res_load;
  logic [COLOR_W-1:0] res_color_r, res_color_nxt;
  logic [IDX_W-1:0]   res_idx_r, res_idx_nxt;
  logic [DIST_W-1:0]  res_dist_r, res_dist_nxt;
  logic               out_valid_r;
  logic [COLOR_W-1:0] out_color_r;
  logic [IDX_W-1:0]   out_idx_r;
  logic [DIST_W-1:0]  out_dist_r;

  // input side
  assign out_free = !out_valid_r || out_rsp.ready;
  assign in_ready = (state_r == S_IDLE) || ((state_r == S_DONE) && out_free);
  assign in_acc   = in_req.valid && in_ready;
  assign req_sel  = req_t'(in_req.req_type);
  assign in_range = {1'b0, in_req.entry_index} < ENTRY_LIM;
  assign in_req.ready = in_ready;

  // memory port control
  assign done_scan = (state_r == S_SCAN) && have_best_r
                     && ((best_d_r == '0) || last_seen_r);
  assign issue     = (state_r == S_SCAN) && (scan_addr_r != SCAN_END) && !done_scan;
  assign rd_addr   = (state_r == S_SCAN) ? scan_addr_r[AW-1:0]
                                         : in_req.entry_index[AW-1:0];
  assign mem_re    = issue || (in_acc && (req_sel == REQ_LOOKUP));
  assign mem_we    = in_acc && (req_sel == REQ_WRITE) && in_range;
  assign wr_addr   = in_req.entry_index[AW-1:0];
  assign wr_color  = pack565(in_req.red, in_req.green, in_req.blue);

  // palette storage, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_color;
    end
    if (mem_re) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // valid bits stand in for the zero reset of the palette
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (mem_we) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_vld_r <= vld_r[rd_addr];
    end
  end

  // entry color as read, never-written entries read as zero
  assign ent_color = rd_vld_r ? rd_data_r : '0;

  // state of the next item on accept
  always_comb begin
    case (req_sel)
      REQ_WRITE:  acc_state = S_DONE;
      REQ_LOOKUP: acc_state = S_LOOK;
      REQ_SEARCH: acc_state = S_SCAN;
      default:    acc_state = S_DONE;
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) state_nxt = acc_state;
      end
      S_DONE: begin
        if (in_acc) begin
          state_nxt = acc_state;
        end else if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_LOOK: state_nxt = S_DONE;
      S_SCAN: begin
        if (done_scan) state_nxt = S_DONE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // lookup range flag
  always_ff @(posedge clk) begin
    if (in_acc) begin
      look_ok_r <= in_range;
    end
  end

  // search: address counter and request color
  always_ff @(posedge clk) begin
    if (in_acc && (req_sel == REQ_SEARCH)) begin
      scan_addr_r  <= '0;
      srch_red_r   <= in_req.red;
      srch_green_r <= in_req.green;
      srch_blue_r  <= in_req.blue;
    end else if (issue) begin
      scan_addr_r <= scan_addr_r + CW'(1);
    end
  end

  // search: read and distance stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_live_r   <= 1'b0;
      dist_live_r <= 1'b0;
    end else begin
      rd_live_r   <= issue;
      dist_live_r <= rd_live_r && !done_scan;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r     <= scan_addr_r[AW-1:0];
    dist_r       <= color_dist(ent_color, srch_red_r, srch_green_r, srch_blue_r);
    dist_idx_r   <= rd_idx_r;
    dist_color_r <= ent_color;
  end

  // search: keep the best candidate, strict compare favors the lower index
  assign take = dist_live_r && (!have_best_r || (dist_r < best_d_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_best_r <= 1'b0;
      last_seen_r <= 1'b0;
    end else if (in_acc && (req_sel == REQ_SEARCH)) begin
      have_best_r <= 1'b0;
      last_seen_r <= 1'b0;
    end else begin
      if (take) have_best_r <= 1'b1;
      if (dist_live_r && (dist_idx_r == LAST_IDX)) last_seen_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best_d_r     <= dist_r;
      best_idx_r   <= dist_idx_r;
      best_color_r <= dist_color_r;
    end
  end

  // pending result
  always_comb begin
    res_load      = 1'b0;
    res_color_nxt = '0;
    res_idx_nxt   = '0;
    res_dist_nxt  = '0;
    if (in_acc && (req_sel == REQ_WRITE)) begin
      res_load      = 1'b1;
      res_color_nxt = wr_color;
    end else if (in_acc && (req_sel != REQ_LOOKUP) && (req_sel != REQ_SEARCH)) begin
      res_load = 1'b1;
    end else if (state_r == S_LOOK) begin
      res_load      = 1'b1;
      res_color_nxt = look_ok_r ? ent_color : '0;
    end else if (done_scan) begin
      res_load      = 1'b1;
      res_color_nxt = best_color_r;
      res_idx_nxt   = IDX_W'(best_idx_r);
      res_dist_nxt  = best_d_r;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_color_r <= res_color_nxt;
      res_idx_r   <= res_idx_nxt;
      res_dist_r  <= res_dist_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == S_DONE) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_DONE) && out_free) begin
      out_color_r <= res_color_r;
      out_idx_r   <= res_idx_r;
      out_dist_r  <= res_dist_r;
    end
  end

  assign out_rsp.valid         = out_valid_r;
  assign out_rsp.color_565     = out_color_r;
  assign out_rsp.best_index    = out_idx_r;
  assign out_rsp.best_distance = out_dist_r;

endmodule

// ===== rtl/ipe_checker.sv =====
// ---------------------------------------------------------------------------
// ipe_checker
// Port-level checks of the indexed palette engine, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ipe_checker import ipe_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [COLOR_W-1:0] out_color_565,
  input logic [IDX_W-1:0]   out_best_index,
  input logic [DIST_W-1:0]  out_best_distance
);

  localparam logic [1:0] PEND_OVER = 2'd3;

  logic       in_xfer, out_xfer;
  logic [1:0] pending_r;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  // items accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else if (in_xfer && !out_xfer) begin
      pending_r <= pending_r + 2'd1;
    end else if (out_xfer && !in_xfer) begin
      pending_r <= pending_r - 2'd1;
    end
  end

  // stalled response holds
  `ASSERT_HOLDS(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_color_565) && $stable(out_best_index) && $stable(out_best_distance), "stalled response changed")

  // no response without an accepted request
  `ASSERT_NEVER(a_no_orphan, clk, rst_n, out_valid && (pending_r == 2'd0), "response without pending request")

  // at most the engine item and the output register are in flight
  `ASSERT_NEVER(a_pend_cap, clk, rst_n, pending_r == PEND_OVER, "too many requests in flight")

  // distance within the rgb range
  `ASSERT_NEVER(a_dist_range, clk, rst_n, out_valid && (out_best_distance > MAX_DIST), "distance out of range")

endmodule

bind indexed_palette_engine_unit ipe_checker u_ipe_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_req.valid),
  .in_ready          (in_req.ready),
  .out_valid         (out_rsp.valid),
  .out_ready         (out_rsp.ready),
  .out_color_565     (out_rsp.color_565),
  .out_best_index    (out_rsp.best_index),
  .out_best_distance (out_rsp.best_distance)
);
